/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clock and reset built in.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define FDTW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FDTW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fdtw_pkg.sv */
// ----------------------------------------------------------------------------
// FDT token walker package
// Token codes, event codes, depth ceiling and the result item type.
// ----------------------------------------------------------------------------
package fdtw_pkg;

  localparam int DEPTH_LIMIT = 255;
  localparam logic [7:0] DEPTH_CEIL = 8'((DEPTH_LIMIT < 255) ? DEPTH_LIMIT : 255);

  // structure block tokens
  localparam logic [31:0] TOK_BEGIN_NODE = 32'h1;
  localparam logic [31:0] TOK_END_NODE   = 32'h2;
  localparam logic [31:0] TOK_PROP       = 32'h3;
  localparam logic [31:0] TOK_NOP        = 32'h4;
  localparam logic [31:0] TOK_BEGIN_ALT  = 32'h6;
  localparam logic [31:0] TOK_END        = 32'h9;

  // result event codes
  localparam logic [3:0] EV_NOP     = 4'd0;
  localparam logic [3:0] EV_BEGIN   = 4'd1;
  localparam logic [3:0] EV_NAME    = 4'd2;
  localparam logic [3:0] EV_ENDNODE = 4'd3;
  localparam logic [3:0] EV_PROP    = 4'd4;
  localparam logic [3:0] EV_PAYLOAD = 4'd5;
  localparam logic [3:0] EV_END     = 4'd6;
  localparam logic [3:0] EV_ERROR   = 4'd7;
  localparam logic [3:0] EV_AFTER   = 4'd8;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  depth;
    logic [31:0] prop_bytes;
    logic [31:0] string_offset;
    logic [31:0] word_out;
    logic        name_last;
  } fdtw_result_t;

endpackage

/* rtl/core/fdtw_if.sv */
// ----------------------------------------------------------------------------
// FDT token walker channels
// Valid/ready channels for structure words in and walker results out.
// ----------------------------------------------------------------------------
interface fdtw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] token_word;

  modport source (output valid, output token_word, input ready);
  modport sink (input valid, input token_word, output ready);
endinterface

interface fdtw_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  depth;
  logic [31:0] prop_bytes;
  logic [31:0] string_offset;
  logic [31:0] word_out;
  logic        name_last;

  modport source (output valid, output event_res, output depth, output prop_bytes,
                  output string_offset, output word_out, output name_last, input ready);
  modport sink (input valid, input event_res, input depth, input prop_bytes,
                input string_offset, input word_out, input name_last, output ready);
endinterface

/* rtl/core/fdt_structure_token_walker.sv */
// ----------------------------------------------------------------------------
// FDT structure token walker
// Parses the device tree structure block one 32-bit word per item.
// ----------------------------------------------------------------------------
// Each accepted structure word yields exactly one result item, and a new word
// is taken every cycle with ready high: the walker state updates in the same
// cycle the word is accepted and the result lands in a single output register.
// Input ready falls only while that register holds an item the sink has not
// taken. Words are big-endian as stored in memory; node names pass through up
// to the word holding a zero byte, property payloads pass through rounded up
// to whole words, an unknown token locks the error event until reset, and
// every word after the end token reports the after-end event.
module fdt_structure_token_walker import fdtw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdtw_in_if.sink    token_i,
  fdtw_out_if.source result_o
);

  logic         step;
  logic         out_free;
  fdtw_result_t res;

  assign token_i.ready = out_free;
  assign step = token_i.valid && out_free;

  fdtw_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (token_i.token_word),
    .res_o  (res)
  );

  fdtw_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

/* rtl/core/fdtw_walker.sv */
// ----------------------------------------------------------------------------
// FDT token walker state
// Classifies one structure word per step and advances the parse state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdtw_walker import fdtw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [31:0]  word_i,
  output fdtw_result_t res_o
);

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_NAME,
    PH_LEN,
    PH_OFF,
    PH_PAYLOAD,
    PH_DONE,
    PH_ERROR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  depth_q, depth_d;
  logic [29:0] payload_left_q, payload_left_d;
  logic [31:0] held_length_q, held_length_d;
  logic [31:0] len_minus_one;
  logic        zero_byte;

  assign zero_byte = (word_i[31:24] == 8'd0) || (word_i[23:16] == 8'd0) ||
                     (word_i[15:8] == 8'd0) || (word_i[7:0] == 8'd0);
  assign len_minus_one = held_length_q - 32'd1;

  always_comb begin
    phase_d        = phase_q;
    depth_d        = depth_q;
    payload_left_d = payload_left_q;
    held_length_d  = held_length_q;
    res_o          = '0;
    res_o.event_res = EV_ERROR;

    case (phase_q)
      PH_TOKEN: begin
        case (word_i)
          TOK_NOP: res_o.event_res = EV_NOP;
          TOK_BEGIN_NODE, TOK_BEGIN_ALT: begin
            res_o.event_res = EV_BEGIN;
            if (depth_q < DEPTH_CEIL) depth_d = depth_q + 8'd1;
            phase_d = PH_NAME;
          end
          TOK_END_NODE: begin
            res_o.event_res = EV_ENDNODE;
            if (depth_q != 8'd0) depth_d = depth_q - 8'd1;
          end
          TOK_PROP: begin
            res_o.event_res = EV_PROP;
            phase_d = PH_LEN;
          end
          TOK_END: begin
            res_o.event_res = EV_END;
            phase_d = PH_DONE;
          end
          default: begin
            res_o.event_res = EV_ERROR;
            phase_d = PH_ERROR;
          end
        endcase
      end
      PH_NAME: begin
        res_o.event_res = EV_NAME;
        res_o.word_out  = word_i;
        if (zero_byte) begin
          res_o.name_last = 1'b1;
          phase_d = PH_TOKEN;
        end
      end
      PH_LEN: begin
        res_o.event_res  = EV_PROP;
        res_o.prop_bytes = word_i;
        held_length_d    = word_i;
        phase_d          = PH_OFF;
      end
      PH_OFF: begin
        res_o.event_res     = EV_PROP;
        res_o.prop_bytes    = held_length_q;
        res_o.string_offset = word_i;
        if (held_length_q == 32'd0) begin
          phase_d = PH_TOKEN;
        end else begin
          // words owed after the first payload word
          payload_left_d = len_minus_one[31:2];
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_o.event_res = EV_PAYLOAD;
        res_o.word_out  = word_i;
        if (payload_left_q == 30'd0) phase_d = PH_TOKEN;
        else payload_left_d = payload_left_q - 30'd1;
      end
      PH_DONE: res_o.event_res = EV_AFTER;
      default: begin
        res_o.event_res = EV_ERROR;
        phase_d = PH_ERROR;
      end
    endcase

    res_o.depth = depth_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_TOKEN;
      depth_q        <= 8'd0;
      payload_left_q <= 30'd0;
      held_length_q  <= 32'd0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      depth_q        <= depth_d;
      payload_left_q <= payload_left_d;
      held_length_q  <= held_length_d;
    end
  end

  `FDTW_ASSERT(depth_ceil_a, clk_i, rst_ni, depth_q <= DEPTH_CEIL, "depth above ceiling")
  `FDTW_ASSERT(payload_len_a, clk_i, rst_ni,
               (phase_q != PH_PAYLOAD) || (held_length_q != 32'd0),
               "payload phase with zero length")
  `FDTW_ASSERT_NEXT(error_sticky_a, clk_i, rst_ni, phase_q == PH_ERROR,
                    phase_q == PH_ERROR, "left error state")
  `FDTW_ASSERT_NEXT(done_sticky_a, clk_i, rst_ni, phase_q == PH_DONE,
                    phase_q == PH_DONE, "left done state")

endmodule

/* rtl/core/fdtw_out_stage.sv */
// ----------------------------------------------------------------------------
// FDT token walker result register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module fdtw_out_stage import fdtw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  fdtw_result_t res_i,
  output logic         free_o,
  fdtw_out_if.source   result_o
);

  logic         valid_q;
  fdtw_result_t res_q;

  // take a new item when empty or when the held one leaves this cycle
  assign free_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) res_q <= res_i;
  end

  assign result_o.valid         = valid_q;
  assign result_o.event_res     = res_q.event_res;
  assign result_o.depth         = res_q.depth;
  assign result_o.prop_bytes    = res_q.prop_bytes;
  assign result_o.string_offset = res_q.string_offset;
  assign result_o.word_out      = res_q.word_out;
  assign result_o.name_last     = res_q.name_last;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// FDT structure token walker testbench
// Streams structure-block words into the walker and checks every result item
// against an in-bench walk of the same stream. The stream runs as a short
// directed part, then mostly well-formed random trees, and ends in one sticky
// state. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import fdtw_pkg::*;

  typedef enum logic [2:0] {
    WALK_TOKEN, WALK_NAME, WALK_LEN, WALK_OFF, WALK_PAYLOAD, WALK_DONE, WALK_ERROR
  } walk_phase_e;

  class token_walk_model;
    walk_phase_e  phase;
    logic [7:0]   nest;
    logic [29:0]  payload_left;
    logic [31:0]  held_length;
    fdtw_result_t owed_results[$];
    int           faults;

    function new();
      phase        = WALK_TOKEN;
      nest         = '0;
      payload_left = '0;
      held_length  = '0;
      faults       = 0;
    endfunction

    function fdtw_result_t walk_word(logic [31:0] w);
      fdtw_result_t r;
      r = '0;
      r.event_res = EV_ERROR;
      case (phase)
        WALK_TOKEN: begin
          if (w == TOK_NOP) begin
            r.event_res = EV_NOP;
          end else if (w == TOK_BEGIN_NODE || w == TOK_BEGIN_ALT) begin
            r.event_res = EV_BEGIN;
            if (nest < DEPTH_CEIL) nest = nest + 8'd1;
            phase = WALK_NAME;
          end else if (w == TOK_END_NODE) begin
            r.event_res = EV_ENDNODE;
            if (nest != 8'd0) nest = nest - 8'd1;
          end else if (w == TOK_PROP) begin
            r.event_res = EV_PROP;
            phase = WALK_LEN;
          end else if (w == TOK_END) begin
            r.event_res = EV_END;
            phase = WALK_DONE;
          end else begin
            phase = WALK_ERROR;
          end
        end
        WALK_NAME: begin
          r.event_res = EV_NAME;
          r.word_out = w;
          if (w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 ||
              w[7:0] == 8'h00) begin
            r.name_last = 1'b1;
            phase = WALK_TOKEN;
          end
        end
        WALK_LEN: begin
          r.event_res = EV_PROP;
          held_length = w;
          r.prop_bytes = w;
          phase = WALK_OFF;
        end
        WALK_OFF: begin
          r.event_res = EV_PROP;
          r.prop_bytes = held_length;
          r.string_offset = w;
          if (held_length == 32'd0) begin
            phase = WALK_TOKEN;
          end else begin
            // count the words owed after the first payload word
            payload_left = 30'((held_length - 32'd1) >> 2);
            phase = WALK_PAYLOAD;
          end
        end
        WALK_PAYLOAD: begin
          r.event_res = EV_PAYLOAD;
          r.word_out = w;
          if (payload_left == 30'd0) phase = WALK_TOKEN;
          else payload_left = payload_left - 30'd1;
        end
        WALK_DONE: begin
          r.event_res = EV_AFTER;
        end
        default: begin
          phase = WALK_ERROR;
        end
      endcase
      r.depth = nest;
      return r;
    endfunction

    function void take_word(logic [31:0] w);
      owed_results.push_back(walk_word(w));
    endfunction

    function string show(fdtw_result_t r);
      return $sformatf("ev=%0d depth=%0d bytes=%h off=%h word=%h last=%0d",
                       r.event_res, r.depth, r.prop_bytes, r.string_offset,
                       r.word_out, r.name_last);
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    function void match_result(fdtw_result_t got);
      fdtw_result_t want;
      bit           bad;
      if (owed_results.size() == 0) begin
        note_fault({"unexpected result item: ", show(got)});
        return;
      end
      want = owed_results.pop_front();
      bad = (got.event_res !== want.event_res) || (got.depth !== want.depth) ||
            (got.prop_bytes !== want.prop_bytes) ||
            (got.string_offset !== want.string_offset) ||
            (got.word_out !== want.word_out) || (got.name_last !== want.name_last);
      if (bad) note_fault({"result mismatch: expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fdtw_in_if  word_ch ();
  fdtw_out_if res_ch ();

  token_walk_model book = new();

  int hold_off_cycles = 0;
  bit calm = 1'b0;
  int source_idle_pct = 20;
  int sink_idle_pct = 20;
  int words_sent = 0;

  fdt_structure_token_walker uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .token_i  (word_ch),
    .result_o (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    word_ch.valid <= 1'b0;
    word_ch.token_word <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver pacing: random stalls, rare long hold-off, none once calm
  initial begin : sink_pacing
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        res_ch.ready <= 1'b0;
        while (hold_off_cycles > 0) begin
          @(posedge clk_i);
          hold_off_cycles--;
        end
      end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0: sink_idle_pct = 0;
          1: sink_idle_pct = 25;
          default: sink_idle_pct = 60;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    fdtw_result_t got;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.event_res     = res_ch.event_res;
      got.depth         = res_ch.depth;
      got.prop_bytes    = res_ch.prop_bytes;
      got.string_offset = res_ch.string_offset;
      got.word_out      = res_ch.word_out;
      got.name_last     = res_ch.name_last;
      book.match_result(got);
    end
  end

  // leave valid high after the handshake unless a gap follows
  task automatic send_word(input logic [31:0] w);
    if (!calm && $urandom_range(0, 99) < source_idle_pct) begin
      word_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    word_ch.valid <= 1'b1;
    word_ch.token_word <= w;
    @(posedge clk_i);
    while (word_ch.ready !== 1'b1) @(posedge clk_i);
    book.take_word(w);
    words_sent++;
  endtask

  task automatic drain_results();
    word_ch.valid <= 1'b0;
    do @(posedge clk_i); while (book.owed_results.size() != 0);
  endtask

  function automatic logic [31:0] name_word(bit last);
    logic [31:0] w;
    logic [3:0]  holes;
    for (int b = 0; b < 4; b++) w[8*b +: 8] = 8'($urandom_range(1, 255));
    if (last) begin
      holes = 4'($urandom_range(1, 15));
      for (int b = 0; b < 4; b++) if (holes[b]) w[8*b +: 8] = 8'h00;
    end
    return w;
  endfunction

  function automatic logic [31:0] begin_token();
    return ($urandom_range(0, 1) != 0) ? TOK_BEGIN_NODE : TOK_BEGIN_ALT;
  endfunction

  task automatic send_node_begin();
    send_word(begin_token());
    repeat ($urandom_range(0, 3)) send_word(name_word(1'b0));
    send_word(name_word(1'b1));
  endtask

  task automatic send_property(input logic [31:0] len);
    send_word(TOK_PROP);
    send_word(len);
    send_word($urandom);
    for (longint k = 0; k < (longint'(len) + 3) / 4; k++) send_word($urandom);
  endtask

  // nest past the ceiling, then unwind below the floor
  task automatic dive_to_ceiling();
    repeat (int'(DEPTH_CEIL) + 4) begin
      send_word(begin_token());
      send_word(name_word(1'b1));
      if ($urandom_range(0, 15) == 0) send_property(32'($urandom_range(0, 12)));
    end
    repeat (int'(DEPTH_CEIL) + 6) send_word(TOK_END_NODE);
  endtask

  initial begin : stimulus
    int          pick;
    bit          dove;
    bit          drained;
    logic [31:0] bad;
    dove = 1'b0;
    drained = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed: floor, nop, name shapes, begin codes, property lengths
    send_word(TOK_END_NODE);
    send_word(TOK_NOP);
    send_word(TOK_BEGIN_NODE);
    send_word(32'h0000_0000);
    send_word(TOK_BEGIN_ALT);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FF00);
    send_word(TOK_BEGIN_NODE);
    send_word(32'h00FF_FFFF);
    send_word(TOK_PROP);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(TOK_PROP);
    send_word(32'h0000_0001);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(TOK_PROP);
    send_word(32'h0000_0005);
    send_word(32'h0000_0012);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    repeat (3) send_word(TOK_END_NODE);

    // block fills while the receiver holds off
    hold_off_cycles = 80;
    while (words_sent < 1500) begin
      if (words_sent % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: source_idle_pct = 0;
          1: source_idle_pct = 20;
          default: source_idle_pct = 50;
        endcase
      end
      if (!dove && words_sent > 400) begin
        dive_to_ceiling();
        dove = 1'b1;
      end
      if (!drained && words_sent > 300) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 28 && book.nest < 8'd16) begin
        send_node_begin();
      end else if (pick < 48) begin
        send_word(TOK_END_NODE);
      end else if (pick < 90) begin
        if ($urandom_range(0, 9) == 0) send_property(32'($urandom_range(0, 260)));
        else send_property(32'($urandom_range(0, 24)));
      end else begin
        send_word(TOK_NOP);
      end
    end

    // end in one sticky state: done, error, or an endless payload
    calm = 1'b1;
    case ($urandom_range(0, 2))
      0: send_word(TOK_END);
      1: begin
        do begin
          bad = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 15)) : 32'($urandom);
        end while (bad == TOK_BEGIN_NODE || bad == TOK_BEGIN_ALT || bad == TOK_END_NODE ||
                   bad == TOK_PROP || bad == TOK_NOP || bad == TOK_END);
        send_word(bad);
      end
      default: begin
        send_word(TOK_PROP);
        send_word($urandom | 32'h8000_0000);
        send_word($urandom);
      end
    endcase
    repeat (150) begin
      send_word(($urandom_range(0, 1) != 0) ? 32'($urandom) : 32'($urandom_range(0, 10)));
    end
    word_ch.valid <= 1'b0;

    while (book.owed_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (book.faults == 0 && book.owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
